FILE: rtl/core/u16u8_pkg.sv
// Package for the UTF-16 to UTF-8 converter: item and job types, result kinds
// and the UTF-8 encoding function. It depends on nothing else.
package u16u8_pkg;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;
  localparam logic [1:0] TAIL_NONE  = 2'd3;

  localparam logic [7:0] BOM_FE = 8'hfe;
  localparam logic [7:0] BOM_FF = 8'hff;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = 1;

  localparam logic [15:0] CAPACITY_RESET = 16'd256;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  kind;
    logic [15:0] consumed;
    logic        run_last;
  } out_item_t;

  typedef struct packed {
    logic [2:0] n;
    logic [3:0][7:0] bytes;
  } enc_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n;
    logic [1:0]      tail;
    logic [15:0]     consumed;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic enc_t utf8_encode(input logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.n = 3'd1;
      e.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      e.n = 3'd2;
      e.bytes[0] = 8'hc0 | {3'b0, cp[10:6]};
      e.bytes[1] = 8'h80 | {2'b0, cp[5:0]};
    end else if (cp < 21'h10000) begin
      e.n = 3'd3;
      e.bytes[0] = 8'he0 | {4'b0, cp[15:12]};
      e.bytes[1] = 8'h80 | {2'b0, cp[11:6]};
      e.bytes[2] = 8'h80 | {2'b0, cp[5:0]};
    end else begin
      e.n = 3'd4;
      e.bytes[0] = 8'hf0 | {5'b0, cp[20:18]};
      e.bytes[1] = 8'h80 | {2'b0, cp[17:12]};
      e.bytes[2] = 8'h80 | {2'b0, cp[11:6]};
      e.bytes[3] = 8'h80 | {2'b0, cp[5:0]};
    end
    return e;
  endfunction

endpackage

FILE: rtl/core/u16u8_front.sv
// Front end of the converter: byte pairing, byte order, surrogates, room
// accounting and encoding into at most one job per input byte. Uses u16u8_pkg.
module u16u8_front import u16u8_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  in_item_t    item,
  input  logic [15:0] capacity,
  output logic        push,
  output job_t        job
);

  localparam int unsigned PW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  logic                   le_r, le_nxt;
  logic                   held_r, held_nxt;
  logic [7:0]             hv_r, hv_nxt;
  logic                   hp_r, hp_nxt;
  logic [9:0]             hu_r, hu_nxt;
  logic [COUNT_WIDTH-1:0] pos_r, pos_nxt;
  logic [15:0]            room_r, room_nxt;
  logic                   halt_r, halt_nxt;
  logic                   start_r, start_nxt;
  logic                   closed_r, closed_nxt;
  logic                   has_res;

  always_comb begin
    logic        pair_done;
    logic        do_enc;
    logic [20:0] cp;
    logic [15:0] unit;
    logic [PW-1:0] pos_ext;
    enc_t        e;
    le_nxt     = le_r;
    held_nxt   = held_r;
    hv_nxt     = hv_r;
    hp_nxt     = hp_r;
    hu_nxt     = hu_r;
    pos_nxt    = pos_r;
    room_nxt   = room_r;
    halt_nxt   = halt_r;
    start_nxt  = start_r;
    closed_nxt = closed_r;
    job        = '0;
    job.tail   = TAIL_NONE;
    pair_done  = 1'b0;
    do_enc     = 1'b0;
    cp         = '0;
    unit       = '0;
    pos_ext    = '0;
    e          = '0;

    if (item.first_byte) begin
      le_nxt     = 1'b0;
      held_nxt   = 1'b0;
      hv_nxt     = '0;
      hp_nxt     = 1'b0;
      hu_nxt     = '0;
      pos_nxt    = '0;
      room_nxt   = capacity;
      halt_nxt   = 1'b0;
      start_nxt  = 1'b1;
      closed_nxt = 1'b0;
    end

    if (!closed_nxt) begin
      if (!halt_nxt) begin
        if (!held_nxt) begin
          hv_nxt   = item.data_byte;
          held_nxt = 1'b1;
        end else begin
          held_nxt = 1'b0;
          if (start_nxt) begin
            start_nxt = 1'b0;
            if (hv_nxt == BOM_FE && item.data_byte == BOM_FF) begin
              pos_nxt   = pos_nxt + COUNT_WIDTH'(2);
              pair_done = 1'b1;
            end else if (hv_nxt == BOM_FF && item.data_byte == BOM_FE) begin
              le_nxt    = 1'b1;
              pos_nxt   = pos_nxt + COUNT_WIDTH'(2);
              pair_done = 1'b1;
            end
          end
          if (!pair_done) begin
            unit = le_nxt ? {item.data_byte, hv_nxt} : {hv_nxt, item.data_byte};
            if (hp_nxt) begin
              hp_nxt = 1'b0;
              if (unit >= 16'hdc00 && unit <= 16'hdfff) begin
                pos_nxt = pos_nxt + COUNT_WIDTH'(2);
                do_enc  = 1'b1;
                cp      = 21'h10000 | {1'b0, hu_nxt, unit[9:0]};
              end else begin
                job.tail   = KIND_ERROR;
                closed_nxt = 1'b1;
                halt_nxt   = 1'b1;
              end
            end else if (room_nxt <= 16'd1) begin
              halt_nxt = 1'b1;
            end else begin
              pos_nxt = pos_nxt + COUNT_WIDTH'(2);
              if (unit >= 16'hd800 && unit <= 16'hdbff) begin
                if (item.last_byte) begin
                  do_enc = 1'b1;
                  cp     = {5'b0, unit};
                end else begin
                  hp_nxt = 1'b1;
                  hu_nxt = unit[9:0];
                end
              end else if (unit >= 16'hdc00 && unit <= 16'hdfff) begin
                job.tail   = KIND_ERROR;
                closed_nxt = 1'b1;
                halt_nxt   = 1'b1;
                hp_nxt     = 1'b0;
              end else begin
                do_enc = 1'b1;
                cp     = {5'b0, unit};
              end
            end
          end
        end
      end

      if (item.last_byte && !closed_nxt) begin
        if (hp_nxt && !halt_nxt) begin
          hp_nxt = 1'b0;
          do_enc = 1'b1;
          cp     = 21'hd800 + 21'(hu_nxt);
        end
        pos_ext      = PW'(pos_nxt);
        job.tail     = KIND_DONE;
        job.consumed = pos_ext[15:0];
        closed_nxt   = 1'b1;
      end

      if (do_enc) begin
        e = utf8_encode(cp);
        if ({13'b0, e.n} >= room_nxt) begin
          room_nxt = '0;
          halt_nxt = 1'b1;
        end else begin
          room_nxt  = room_nxt - {13'b0, e.n};
          job.n     = e.n;
          job.bytes = e.bytes;
        end
      end

      if (job.tail == KIND_DONE) begin
        halt_nxt = 1'b1;
      end
    end
  end

  assign has_res = (job.n != 3'd0) || (job.tail != TAIL_NONE);
  assign push    = accept && has_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      le_r     <= 1'b0;
      held_r   <= 1'b0;
      hv_r     <= '0;
      hp_r     <= 1'b0;
      hu_r     <= '0;
      pos_r    <= '0;
      room_r   <= '0;
      halt_r   <= 1'b0;
      start_r  <= 1'b0;
      closed_r <= 1'b0;
    end else if (accept) begin
      le_r     <= le_nxt;
      held_r   <= held_nxt;
      hv_r     <= hv_nxt;
      hp_r     <= hp_nxt;
      hu_r     <= hu_nxt;
      pos_r    <= pos_nxt;
      room_r   <= room_nxt;
      halt_r   <= halt_nxt;
      start_r  <= start_nxt;
      closed_r <= closed_nxt;
    end
  end

endmodule

FILE: rtl/core/u16u8_queue.sv
// Short job queue between the front and back ends of the converter.
// Uses job_t and q_stat_t from u16u8_pkg.
module u16u8_queue import u16u8_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t stat
);

  localparam logic [QUEUE_AW:0] DEPTH_C = (QUEUE_AW + 1)'(QUEUE_DEPTH);

  job_t                entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_r, wp_nxt;
  logic [QUEUE_AW-1:0] rp_r, rp_nxt;
  logic [QUEUE_AW:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == DEPTH_C);
  assign stat.empty = (cnt_r == '0);
  assign head       = entry_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wp_r] <= push_job;
    end
  end

endmodule

FILE: rtl/core/u16u8_back.sv
// Back end of the converter: unpacks the head job into result words, one a
// cycle when not stalled, through an output register. Uses u16u8_pkg.
module u16u8_back import u16u8_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      head,
  input  q_stat_t   stat,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic       out_valid_r;
  out_item_t  out_data_r;
  logic [2:0] idx_r, idx_nxt;
  logic [2:0] total;
  logic       load;
  logic       last_item;
  out_item_t  word;

  assign total     = head.n + {2'b0, head.tail != TAIL_NONE};
  assign last_item = (idx_r + 3'd1) == total;
  assign load      = !stat.empty && (!out_valid_r || out_ready);
  assign pop       = load && last_item;

  always_comb begin
    word          = '0;
    word.run_last = last_item;
    if (idx_r < head.n) begin
      word.kind     = KIND_DATA;
      word.out_byte = head.bytes[idx_r[1:0]];
    end else begin
      word.kind = head.tail;
      if (head.tail == KIND_DONE) begin
        word.consumed = head.consumed;
      end
    end
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = last_item ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/utf16_to_utf8_converter_unit.sv
// UTF-16 to UTF-8 converter, one input byte per word in and one UTF-8 byte,
// done or error word out. Instantiates u16u8_front, u16u8_queue, u16u8_back.
//
// Input bytes are accepted one a cycle while the two-entry job queue has room.
// Each input byte yields zero to five result words, and the back end issues
// one result word a cycle while the output is not stalled, through its output
// register; the queue lets the front end take further input bytes while the
// back end is still unpacking earlier jobs. The output capacity register
// sits at byte address 0 and takes effect when the next string opens.
module utf16_to_utf8_converter_unit import u16u8_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] cap_r;
  logic        accept;
  logic        push;
  logic        pop;
  job_t        push_job;
  job_t        head;
  q_stat_t     stat;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == 1'b0) ? {16'b0, cap_r} : 32'b0;
  assign in_ready = !stat.full;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      cap_r <= pwdata[15:0];
    end
  end

  u16u8_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .item     (in_data),
    .capacity (cap_r),
    .push     (push),
    .job      (push_job)
  );

  u16u8_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  u16u8_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the UTF-16 to UTF-8 converter unit. It drives byte
// strings through the valid/ready channels, sets the capacity over APB and checks
// every result word against an in-line model. Needs u16u8_pkg and the unit's RTL.
module tb_top import u16u8_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  CAPACITY_ADDR = 3'd0;
  localparam logic [15:0] BOM_UNIT      = {BOM_FE, BOM_FF};
  localparam logic [15:0] HIGH_BASE     = 16'hd800;
  localparam logic [15:0] LOW_BASE      = 16'hdc00;
  localparam logic [5:0]  HIGH_TAG      = 6'b110110;
  localparam logic [5:0]  LOW_TAG       = 6'b110111;
  localparam int unsigned SETTLE        = 16;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned TAIL_UNITS    = 6;

  typedef struct packed {
    in_item_t  word;
    logic      typed;
    out_item_t want;
  } script_row_t;

  // Opening rows: bytes before any string is opened, a one-byte string, a big-endian
  // string with the extreme units and a trailing high surrogate, then the two errors.
  localparam script_row_t SCRIPT [26] = '{
    '{'{8'h41, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h42, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0, 1'b1}, 1'b1, '{8'h00, KIND_DONE, 16'd0, 1'b1}},
    '{'{8'h55, 1'b0, 1'b1}, 1'b0, '0},
    '{'{8'h7a, 1'b1, 1'b1}, 1'b1, '{8'h00, KIND_DONE, 16'd0, 1'b1}},
    '{'{8'hfe, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'hff, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'hdb, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'hff, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'hdf, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'hff, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'hff, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'hff, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'hd8, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h7f, 1'b0, 1'b1}, 1'b0, '0},
    '{'{8'hff, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'hfe, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'hdc, 1'b0, 1'b0}, 1'b1, '{8'h00, KIND_ERROR, 16'd0, 1'b1}},
    '{'{8'hd8, 1'b1, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h41, 1'b0, 1'b0}, 1'b1, '{8'h00, KIND_ERROR, 16'd0, 1'b1}}
  };

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  // Model state of the converter.
  logic [15:0] cap_reg     = CAPACITY_RESET;
  logic        le_order    = 1'b0;
  logic        held_valid  = 1'b0;
  logic [7:0]  held_byte   = '0;
  logic        surr_wait   = 1'b0;
  logic [9:0]  surr_bits   = '0;
  logic [15:0] count_pos   = '0;
  logic [15:0] room        = '0;
  logic        dropped     = 1'b0;
  logic        bom_window  = 1'b0;
  logic        string_shut = 1'b0;

  out_item_t   step_words [$];
  out_item_t   owed_words [$];
  out_item_t   head;
  logic        gaps_on     = 1'b1;
  int unsigned words_sent  = 0;
  int unsigned fault_count = 0;
  int unsigned quiet_cycles;

  utf16_to_utf8_converter_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic emit_code_point(input logic [20:0] cp);
    int unsigned n;
    logic [7:0]  seq [4];
    logic [20:0] rest;
    n = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
    if (n >= room) begin
      room = '0;
      dropped = 1'b1;
      return;
    end
    room = room - 16'(n);
    rest = cp;
    for (int j = n - 1; j > 0; j--) begin
      seq[j] = {2'b10, rest[5:0]};
      rest = rest >> 6;
    end
    case (n)
      1: seq[0] = rest[7:0];
      2: seq[0] = rest[7:0] | 8'hc0;
      3: seq[0] = rest[7:0] | 8'he0;
      default: seq[0] = rest[7:0] | 8'hf0;
    endcase
    for (int j = 0; j < n; j++) begin
      step_words.push_back(out_item_t'{seq[j], KIND_DATA, 16'd0, 1'b0});
    end
  endtask

  task automatic abort_string();
    step_words.push_back(out_item_t'{8'h00, KIND_ERROR, 16'd0, 1'b0});
    string_shut = 1'b1;
    dropped = 1'b1;
    surr_wait = 1'b0;
  endtask

  task automatic take_unit(input logic [7:0] hi, input logic [7:0] lo, input logic last);
    logic [15:0] unit;
    if (bom_window) begin
      bom_window = 1'b0;
      if (hi == BOM_FE && lo == BOM_FF) begin
        count_pos += 16'd2;
        return;
      end
      if (hi == BOM_FF && lo == BOM_FE) begin
        le_order = 1'b1;
        count_pos += 16'd2;
        return;
      end
    end
    unit = le_order ? {lo, hi} : {hi, lo};
    if (surr_wait) begin
      surr_wait = 1'b0;
      if (unit[15:10] == LOW_TAG) begin
        count_pos += 16'd2;
        emit_code_point(21'h10000 | {1'b0, surr_bits, unit[9:0]});
      end else begin
        abort_string();
      end
      return;
    end
    if (room <= 16'd1) begin
      dropped = 1'b1;
      return;
    end
    count_pos += 16'd2;
    if (unit[15:10] == HIGH_TAG) begin
      if (last) begin
        emit_code_point({5'd0, unit});
      end else begin
        surr_wait = 1'b1;
        surr_bits = unit[9:0];
      end
    end else if (unit[15:10] == LOW_TAG) begin
      abort_string();
    end else begin
      emit_code_point({5'd0, unit});
    end
  endtask

  task automatic transcode_byte(input in_item_t w);
    out_item_t tail;
    step_words.delete();
    if (w.first_byte) begin
      le_order = 1'b0;
      held_valid = 1'b0;
      held_byte = '0;
      surr_wait = 1'b0;
      surr_bits = '0;
      count_pos = '0;
      room = cap_reg;
      dropped = 1'b0;
      bom_window = 1'b1;
      string_shut = 1'b0;
    end
    if (string_shut) return;
    if (!dropped) begin
      if (!held_valid) begin
        held_byte = w.data_byte;
        held_valid = 1'b1;
      end else begin
        held_valid = 1'b0;
        take_unit(held_byte, w.data_byte, w.last_byte);
      end
    end
    if (w.last_byte && !string_shut) begin
      if (surr_wait && !dropped) begin
        surr_wait = 1'b0;
        emit_code_point({5'd0, HIGH_TAG, surr_bits});
      end
      step_words.push_back(out_item_t'{8'h00, KIND_DONE, count_pos, 1'b0});
      string_shut = 1'b1;
      dropped = 1'b1;
    end
    if (step_words.size() > 0) begin
      tail = step_words.pop_back();
      tail.run_last = 1'b1;
      step_words.push_back(tail);
    end
  endtask

  task automatic send_word(input in_item_t w, input logic typed, input out_item_t want);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 39) == 0) begin
      in_valid <= 1'b0;
      do @(negedge clk); while (owed_words.size() != 0);
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    transcode_byte(w);
    if (typed) begin
      owed_words.push_back(want);
    end else begin
      foreach (step_words[k]) owed_words.push_back(step_words[k]);
    end
  endtask

  function automatic logic [15:0] plain_unit();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 16'h7f));
      1: return 16'($urandom_range(16'h80, 16'h7ff));
      2: return 16'($urandom_range(16'h800, 16'hd7ff));
      default: return 16'($urandom_range(16'he000, 16'hffff));
    endcase
  endfunction

  task automatic send_string(input int unsigned n_units);
    logic [15:0] units [$];
    logic [7:0]  body [$];
    logic        swap;
    logic        closing;
    int unsigned pick;
    in_item_t    w;
    swap = 1'b0;
    pick = $urandom_range(0, 2);
    if (pick != 0) units.push_back(BOM_UNIT);
    if (pick == 2) swap = 1'b1;
    repeat (n_units) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        units.push_back(plain_unit());
      end else if (pick < 17) begin
        units.push_back(HIGH_BASE | 16'($urandom_range(0, 1023)));
        units.push_back(LOW_BASE | 16'($urandom_range(0, 1023)));
      end else if (pick == 17) begin
        units.push_back(LOW_BASE | 16'($urandom_range(0, 1023)));
      end else if (pick == 18) begin
        units.push_back(HIGH_BASE | 16'($urandom_range(0, 1023)));
        units.push_back(plain_unit());
      end else begin
        units.push_back(16'($urandom));
      end
    end
    pick = $urandom_range(0, 19);
    closing = (pick >= 3);
    if (pick >= 3 && pick < 6) units.push_back(HIGH_BASE | 16'($urandom_range(0, 1023)));
    foreach (units[k]) begin
      if (swap) begin
        body.push_back(units[k][7:0]);
        body.push_back(units[k][15:8]);
      end else begin
        body.push_back(units[k][15:8]);
        body.push_back(units[k][7:0]);
      end
    end
    if (pick >= 6 && pick < 9) body.push_back(8'($urandom));
    foreach (body[k]) begin
      w.data_byte  = body[k];
      w.first_byte = (k == 0);
      w.last_byte  = closing && (k == body.size() - 1);
      send_word(w, 1'b0, '0);
    end
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        w = 10'($urandom);
        send_word(w, 1'b0, '0);
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    do @(negedge clk); while (owed_words.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= {16'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cap_reg = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      fault_count++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (owed_words.size() == 0) begin
        fault_count++;
        $display("%0t: expected no word, got byte %0h kind %0d consumed %0d last %0d",
                 $time, out_data.out_byte, out_data.kind, out_data.consumed,
                 out_data.run_last);
      end else begin
        head = owed_words.pop_front();
        check_field("out_byte", head.out_byte, out_data.out_byte);
        check_field("kind", head.kind, out_data.kind);
        check_field("consumed", head.consumed, out_data.consumed);
        check_field("run_last", head.run_last, out_data.run_last);
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [15:0] caps [$];
    int unsigned start;
    in_item_t    w;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    foreach (SCRIPT[i]) send_word(SCRIPT[i].word, SCRIPT[i].typed, SCRIPT[i].want);

    caps = {16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd0, 16'hffff,
            16'($urandom_range(6, 24)), 16'($urandom_range(1, 65535))};
    foreach (caps[p]) begin
      wait_drained();
      write_capacity(caps[p]);
      gaps_on <= (p % 3 != 2);
      start = words_sent;
      while (words_sent - start < 5) send_string($urandom_range(1, 3));
    end

    // One closing string of ASCII units, sent with no idling on either side.
    wait_drained();
    write_capacity(16'hffff);
    gaps_on <= 1'b0;
    for (int k = 0; k < TAIL_UNITS; k++) begin
      w = '{data_byte: 8'h00, first_byte: (k == 0), last_byte: 1'b0};
      send_word(w, 1'b0, '0);
      w = '{data_byte: 8'($urandom_range(0, 127)), first_byte: 1'b0,
            last_byte: (k == TAIL_UNITS - 1)};
      send_word(w, 1'b0, '0);
    end

    wait_drained();
    if (fault_count == 0 && owed_words.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
